/* sv/bpds_pkg.sv */
`default_nettype none
package bpds_pkg;

   // field widths
   localparam int WORD_W      = 16;
   localparam int CC_W        = 7;
   localparam int LEVEL_W     = 8;
   localparam int LOW_SHIFT   = 12;
   localparam int CC_LSB      = 9;
   localparam int PROD_W      = WORD_W + LEVEL_W;
   localparam int DIV_STEPS   = PROD_W;
   localparam int STEP_CNT_W  = $clog2(DIV_STEPS);

   // stream widths
   localparam int REQ_TDATA_W = 2 * WORD_W;
   localparam int RSP_FIELD_W = CC_W + 2 * WORD_W + LEVEL_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [WORD_W-1:0]  FULL_CODE = '1;
   localparam logic [LEVEL_W-1:0] LED_SPAN  = 8'd255;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture the sample of an accepted word
      logic calib;     // capture baseline and full scale
      logic compare;   // form excursions and the dividend
      logic step;      // one restoring division step
      logic out_load;  // move the result into the output register
   } cmd_type;

endpackage
`default_nettype wire

/* sv/bpds_ctrl.sv */
`default_nettype none
module bpds_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output bpds_pkg::cmd_type     cmd
);
   import bpds_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_COMPARE = 4'b0010,
      ST_DIVIDE  = 4'b0100,
      ST_FINISH  = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      PH_WAIT  = 2'd0,
      PH_BASE  = 2'd1,
      PH_READY = 2'd2
   } phase_type;

   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [STEP_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign accept     = req_tvalid && req_tready;

   // sequencer
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load  = 1'b1;
               cmd.calib = (phase_ff == PH_BASE);
               if (phase_ff == PH_WAIT) begin
                  phase_in = PH_BASE;
               end else if (phase_ff == PH_BASE) begin
                  phase_in = PH_READY;
               end
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            cnt_in      = '0;
            state_in    = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + STEP_CNT_W'(1);
            if (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output word valid flag
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_WAIT;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

/* sv/bpds_dp.sv */
`default_nettype none
module bpds_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bpds_pkg::cmd_type                 cmd,
   input  wire logic [bpds_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                              csr_wr_en,
   input  wire logic [bpds_pkg::WORD_W-1:0]       csr_wr_data,
   output logic [bpds_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                   rsp_tuser
);
   import bpds_pkg::*;

   logic [WORD_W-1:0]   deadband_ff;
   logic [WORD_W-1:0]   baseline_ff;
   logic [WORD_W-1:0]   full_scale_ff;
   logic [WORD_W-1:0]   sample_ff;
   logic [WORD_W-1:0]   sample_in;
   logic [WORD_W-1:0]   up_ff, up_in;
   logic [WORD_W-1:0]   down_ff, down_in;
   logic [PROD_W-1:0]   dvd_ff, dvd_in;
   logic [WORD_W-1:0]   rem_ff, rem_in;
   logic [WORD_W:0]     trial;
   logic                fits;
   logic signed [WORD_W+1:0] s_ext, low_edge, high_edge, diff_lo, diff_hi;
   logic [CC_W-1:0]     cc_ff;
   logic [WORD_W-1:0]   out_up_ff, out_down_ff;
   logic                led_write_ff, led_write_in;
   logic [LEVEL_W-1:0]  led_level_ff, led_level_in;

   // sample assembly: high word bits 11..0 over low word bits 15..12
   assign sample_in = {req_tdata[WORD_W-LOW_SHIFT+LOW_SHIFT-5:0],
                       req_tdata[REQ_TDATA_W-1 -: (WORD_W-LOW_SHIFT)]};

   // deadband register
   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= '0;
      end else if (csr_wr_en) begin
         deadband_ff <= csr_wr_data;
      end
   end

   // calibration capture
   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff   <= '0;
         full_scale_ff <= '0;
      end else if (cmd.calib) begin
         baseline_ff   <= sample_in;
         full_scale_ff <= FULL_CODE - sample_in + deadband_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= sample_in;
      end
   end

   // deadband compare in 18-bit signed
   always_comb begin
      s_ext     = $signed({2'b00, sample_ff});
      low_edge  = $signed({2'b00, baseline_ff}) - $signed({2'b00, deadband_ff});
      high_edge = $signed({2'b00, baseline_ff}) + $signed({2'b00, deadband_ff});
      diff_lo   = low_edge - s_ext;
      diff_hi   = s_ext - high_edge;
      up_in     = '0;
      down_in   = '0;
      if (s_ext < low_edge) begin
         down_in = diff_lo[WORD_W-1:0];
      end else if (s_ext > high_edge) begin
         up_in = diff_hi[WORD_W-1:0];
      end
   end

   // restoring divider, quotient shifts into the dividend register
   always_comb begin
      trial  = {rem_ff, dvd_ff[PROD_W-1]};
      fits   = (trial >= {1'b0, full_scale_ff});
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      if (cmd.compare) begin
         rem_in = '0;
         dvd_in = PROD_W'(up_in) * PROD_W'(LED_SPAN);
      end else if (cmd.step) begin
         if (fits) begin
            rem_in = WORD_W'(trial - {1'b0, full_scale_ff});
         end else begin
            rem_in = trial[WORD_W-1:0];
         end
         dvd_in = {dvd_ff[PROD_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      if (cmd.compare) begin
         up_ff   <= up_in;
         down_ff <= down_in;
      end
   end

   // led rule
   always_comb begin
      led_write_in = 1'b0;
      led_level_in = '0;
      if ((up_ff == '0) && (down_ff == '0)) begin
         led_write_in = 1'b1;
      end else if ((up_ff != '0) && (full_scale_ff != '0)) begin
         led_write_in = 1'b1;
         led_level_in = dvd_ff[LEVEL_W:1];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         cc_ff        <= up_ff[CC_LSB +: CC_W];
         out_up_ff    <= up_ff;
         out_down_ff  <= down_ff;
         led_write_ff <= led_write_in;
         led_level_ff <= led_level_in;
      end
   end

   assign rsp_tdata = RSP_TDATA_W'({led_level_ff, out_down_ff, out_up_ff, cc_ff});
   assign rsp_tuser = led_write_ff;

endmodule
`default_nettype wire

/* sv/breath_pressure_deadband_scaler_core.sv */
`default_nettype none
// channel   dir  handshake                 payload
// req       in   req_tvalid / req_tready   req_tdata: high_word, low_word
// rsp       out  rsp_tvalid / rsp_tready   rsp_tdata: cc_value, excursions, led_level
//                                          rsp_tuser: led_write
// csr       in   csr_wr_en                 csr_wr_data: deadband
//
// one word passes through accept, compare, 24 steps of the restoring divider
// for the led level, then the move into the output register.
// a finished word waits in the output register while the next word is taken.
// reset (synchronous) clears the calibration phase, baseline, full scale and
// deadband; the first word after reset is taken at once.
module breath_pressure_deadband_scaler_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [15:0] high_word, [31:16] low_word
   input  wire logic [bpds_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [6:0] cc_value, [22:7] excursion_up, [38:23] excursion_down,
   // [46:39] led_level, [47] zero
   output logic [bpds_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   // [0] led_write
   output logic                                   rsp_tuser,
   input  wire logic                              csr_wr_en,
   input  wire logic [bpds_pkg::WORD_W-1:0]       csr_wr_data
);
   import bpds_pkg::*;

   cmd_type cmd;

   // sequencer
   bpds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // arithmetic and state
   bpds_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import bpds_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_CYCLES = 40;

   // calibration progress of the predictor
   typedef enum logic [1:0] {
      CAL_WAIT_FIRST = 2'd0,
      CAL_WAIT_BASE  = 2'd1,
      CAL_DONE       = 2'd2
   } calib_type;

   typedef struct packed {
      logic [CC_W-1:0]    cc;
      logic [WORD_W-1:0]  up;
      logic [WORD_W-1:0]  down;
      logic               led_wr;
      logic [LEVEL_W-1:0] level;
   } breath_word_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_wr_en;
   logic [WORD_W-1:0]      csr_wr_data;

   // predictor state
   calib_type         calib_state;
   logic [WORD_W-1:0] deadband_q;
   logic [WORD_W-1:0] baseline_q;
   logic [WORD_W-1:0] full_scale_q;

   breath_word_type pending_breath[$];
   int              mismatch_count;
   int              idle_cycles;
   bit              steady;

   breath_pressure_deadband_scaler_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected excursions and led update for one pair of sensor words
   function automatic breath_word_type predict_breath(input logic [WORD_W-1:0] hi,
                                                      input logic [WORD_W-1:0] lo);
      logic [WORD_W-1:0] sample;
      int                s;
      int                low_edge;
      int                high_edge;
      logic [31:0]       up;
      logic [31:0]       down;
      logic [31:0]       level;
      breath_word_type   r;
      sample = {hi[WORD_W-5:0], lo[WORD_W-1:LOW_SHIFT]};
      if (calib_state == CAL_WAIT_FIRST) begin
         calib_state = CAL_WAIT_BASE;
      end else if (calib_state == CAL_WAIT_BASE) begin
         baseline_q   = sample;
         full_scale_q = FULL_CODE - sample + deadband_q;
         calib_state  = CAL_DONE;
      end
      s         = int'(sample);
      low_edge  = int'(baseline_q) - int'(deadband_q);
      high_edge = int'(baseline_q) + int'(deadband_q);
      up   = 32'd0;
      down = 32'd0;
      if (s < low_edge) begin
         down = low_edge - s;
      end else if (s > high_edge) begin
         up = s - high_edge;
      end
      r.up     = up[WORD_W-1:0];
      r.down   = down[WORD_W-1:0];
      r.cc     = up[CC_LSB +: CC_W];
      r.led_wr = 1'b0;
      r.level  = '0;
      // led: zero when inside the deadband, scaled level on upward breath
      if (up == 32'd0 && down == 32'd0) begin
         r.led_wr = 1'b1;
      end else if (up != 32'd0 && full_scale_q != '0) begin
         level    = (up * {24'd0, LED_SPAN}) / {16'd0, full_scale_q} / 32'd2;
         r.led_wr = 1'b1;
         r.level  = level[LEVEL_W-1:0];
      end
      return r;
   endfunction

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %s: expected %0h, got %0h at %0t", name, want, got, $realtime);
      end
   endtask

   // result checking
   always @(posedge clock) begin : check_words
      breath_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_breath.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected word %0h at %0t", rsp_tdata, $realtime);
         end else begin
            want = pending_breath.pop_front();
            report_field("cc_value", 32'(want.cc), 32'(rsp_tdata[6:0]));
            report_field("excursion_up", 32'(want.up), 32'(rsp_tdata[22:7]));
            report_field("excursion_down", 32'(want.down), 32'(rsp_tdata[38:23]));
            report_field("led_level", 32'(want.level), 32'(rsp_tdata[46:39]));
            report_field("led_write", 32'(want.led_wr), 32'(rsp_tuser));
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // result side back-pressure
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = steady ? 0 : int'($urandom_range(0, 15));
         repeat (stall) @(negedge clock) rsp_tready <= 1'b0;
         @(negedge clock) rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   // send one pair of sensor words and record its expected result
   task automatic send_sample(input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] lo);
      int gap;
      gap = steady ? 0 : int'($urandom_range(0, 15));
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {lo, hi};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_breath.push_back(predict_breath(hi, lo));
   endtask

   // send a given pressure sample, unused sensor bits random
   task automatic send_level(input logic [WORD_W-1:0] sample);
      logic [3:0]  top;
      logic [11:0] tail;
      top  = 4'($urandom_range(0, 15));
      tail = 12'($urandom_range(0, 4095));
      send_sample({top, sample[WORD_W-1:4]}, {sample[3:0], tail});
   endtask

   // deadband write once every word has come back
   task automatic set_deadband(input logic [WORD_W-1:0] value);
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_breath.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock) csr_wr_en <= 1'b0;
      deadband_q = value;
   endtask

   // first word with zero full scale, second word captures the baseline
   task automatic test_calibration();
      send_sample(16'h0FFF, 16'hF000);
      set_deadband(16'h8100);
      send_sample(16'h0800, 16'h0000);
   endtask

   // samples on and around the deadband edges
   task automatic test_deadband_edges();
      set_deadband(16'h0000);
      send_level(16'h8000);
      send_level(16'h8001);
      send_level(16'h7FFF);
      send_level(16'hFFFF);
      send_level(16'h0000);
      set_deadband(16'h0010);
      send_level(16'h8010);
      send_level(16'h8011);
      send_level(16'h7FF0);
      send_level(16'h7FEF);
      set_deadband(16'hFFFF);
      send_level(16'h0000);
      send_level(16'hFFFF);
      send_level(16'h8000);
   endtask

   // extreme and alternating sensor words, ignored bits included
   task automatic test_input_bits();
      set_deadband(16'h0100);
      send_sample(16'hFFFF, 16'hFFFF);
      send_sample(16'hF000, 16'h0FFF);
      send_sample(16'h5555, 16'hAAAA);
      send_sample(16'hAAAA, 16'h5555);
   endtask

   // random samples, mostly near the baseline, under several deadbands
   task automatic test_random_breaths();
      logic [WORD_W-1:0] db;
      int                reach;
      int                target;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: db = 16'h0000;
            1: db = 16'hFFFF;
            2: db = WORD_W'($urandom_range(1, 16'h0300));
            default: db = WORD_W'($urandom_range(0, 16'hFFFF));
         endcase
         set_deadband(db);
         for (int i = 0; i < 76; i++) begin
            if (i % 19 == 0) steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) begin
               send_sample(WORD_W'($urandom_range(0, 16'hFFFF)),
                           WORD_W'($urandom_range(0, 16'hFFFF)));
            end else begin
               reach  = int'(db) + 1024;
               target = int'(baseline_q) + int'($urandom_range(0, 2 * reach)) - reach;
               if (target < 0) target = 0;
               if (target > 65535) target = 65535;
               send_level(target[WORD_W-1:0]);
            end
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      steady         = 1'b0;
      mismatch_count = 0;
      idle_cycles    = 0;
      calib_state    = CAL_WAIT_FIRST;
      deadband_q     = '0;
      baseline_q     = '0;
      full_scale_q   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_calibration();
      test_deadband_edges();
      test_input_bits();
      test_random_breaths();

      // drain
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_breath.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
